// ----- sv/keyfob_pwm_packet_encoder_assert.svh -----
// Assertion macros used by the key fob packet encoder sequencer.
`ifndef KEYFOB_PWM_PACKET_ENCODER_ASSERT_SVH
`define KEYFOB_PWM_PACKET_ENCODER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define KFPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KFPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KFPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define KFPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/kfpe_pkg.sv -----
// Types and constants shared by the key fob packet encoder modules.
package kfpe_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_TE_LENGTH       = 2'd0,
        REG_PACKET_REPEATS  = 2'd1,
        REG_PREAMBLE_PULSES = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_idx_t;

    localparam logic [15:0] TE_LENGTH_RST       = 16'd413;
    localparam logic [3:0]  PACKET_REPEATS_RST  = 4'd4;
    localparam logic [4:0]  PREAMBLE_PULSES_RST = 5'd12;

    // Waveform timing in TE slots and symbols.
    localparam logic [6:0] PRE_SLOTS       = 7'd2;
    localparam logic [6:0] GAP1_TE         = 7'd10;
    localparam logic [6:0] BIT_SLOTS       = 7'd3;
    localparam logic [6:0] GAP2_TE         = 7'd39;
    localparam logic [6:0] PACKET_SYMBOLS  = 7'd66;

    // Fixed payload header nibbles.
    localparam logic [7:0] PAYLOAD_HEAD = 8'h20;
    localparam logic [3:0] PAYLOAD_BTN_HI = 4'h2;

    typedef struct packed {
        logic [15:0] te_length;
        logic [3:0]  packet_repeats;
        logic [4:0]  preamble_pulses;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [27:0] key_id;
        logic [3:0]  button_code;
        logic [7:0]  random_byte;
    } item_t;

    typedef struct packed {
        logic tx_level;
        logic busy_res;
        logic burst_done;
    } result_t;

endpackage

// ----- sv/kfpe_seq.sv -----
// Burst sequencer: payload latch, phase and counter state, and per-beat result.
module kfpe_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  kfpe_pkg::item_t  item,
    input  kfpe_pkg::cfg_t   cfg,
    output kfpe_pkg::result_t result
);
    import kfpe_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_GAP1,
        PH_BITS,
        PH_GAP2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  packet_count_reg, packet_count_next;
    logic [6:0]  symbol_index_reg, symbol_index_next;
    logic [5:0]  te_slot_reg, te_slot_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [63:0] payload_reg, payload_next;

    logic        busy;
    logic        cur_bit;
    logic        level;
    logic [6:0]  slot_inc;
    logic [6:0]  sym_inc;
    logic [3:0]  pkt_inc;
    logic [15:0] te_eff;
    logic [6:0]  pre_eff;
    logic [3:0]  rep_eff;
    logic        te_end;

    assign busy     = (phase_reg != PH_IDLE);
    assign cur_bit  = symbol_index_reg[6] ? 1'b1 : payload_reg[~symbol_index_reg[5:0]];
    assign slot_inc = {1'b0, te_slot_reg} + 7'd1;
    assign sym_inc  = symbol_index_reg + 7'd1;
    assign pkt_inc  = packet_count_reg + 4'd1;
    assign te_eff   = (cfg.te_length == 16'd0) ? 16'd1 : cfg.te_length;
    assign pre_eff  = (cfg.preamble_pulses == 5'd0) ? 7'd1 : {2'b00, cfg.preamble_pulses};
    assign rep_eff  = (cfg.packet_repeats == 4'd0) ? 4'd1 : cfg.packet_repeats;
    assign te_end   = (({1'b0, tick_count_reg} + 17'd1) >= {1'b0, te_eff});

    always_comb begin
        unique case (phase_reg)
            PH_PRE:  level = (te_slot_reg == 6'd1);
            PH_BITS: level = (te_slot_reg == 6'd0) || ((te_slot_reg == 6'd1) && !cur_bit);
            default: level = 1'b0;
        endcase
    end

    always_comb begin
        phase_next        = phase_reg;
        packet_count_next = packet_count_reg;
        symbol_index_next = symbol_index_reg;
        te_slot_next      = te_slot_reg;
        tick_count_next   = tick_count_reg;
        payload_next      = payload_reg;
        result            = '0;

        if (item.kind) begin
            result.busy_res = 1'b1;
            if (busy) begin
                result.tx_level = level;
            end else begin
                payload_next = {PAYLOAD_HEAD, PAYLOAD_BTN_HI, item.button_code,
                                item.random_byte, item.random_byte,
                                item.key_id, item.button_code};
                phase_next        = PH_PRE;
                packet_count_next = 4'd0;
                symbol_index_next = 7'd0;
                te_slot_next      = 6'd0;
                tick_count_next   = 16'd0;
            end
        end else if (busy) begin
            result.tx_level = level;
            result.busy_res = 1'b1;
            if (!te_end) begin
                tick_count_next = tick_count_reg + 16'd1;
            end else begin
                tick_count_next = 16'd0;
                te_slot_next    = slot_inc[5:0];
                unique case (phase_reg)
                    PH_PRE: begin
                        if (slot_inc >= PRE_SLOTS) begin
                            te_slot_next = 6'd0;
                            if (sym_inc >= pre_eff) begin
                                phase_next        = PH_GAP1;
                                symbol_index_next = 7'd0;
                            end else begin
                                symbol_index_next = sym_inc;
                            end
                        end
                    end
                    PH_GAP1: begin
                        if (slot_inc >= GAP1_TE) begin
                            te_slot_next      = 6'd0;
                            phase_next        = PH_BITS;
                            symbol_index_next = 7'd0;
                        end
                    end
                    PH_BITS: begin
                        if (slot_inc >= BIT_SLOTS) begin
                            te_slot_next = 6'd0;
                            if (sym_inc >= PACKET_SYMBOLS) begin
                                phase_next        = PH_GAP2;
                                symbol_index_next = 7'd0;
                            end else begin
                                symbol_index_next = sym_inc;
                            end
                        end
                    end
                    PH_GAP2: begin
                        if (slot_inc >= GAP2_TE) begin
                            te_slot_next      = 6'd0;
                            symbol_index_next = 7'd0;
                            if (pkt_inc >= rep_eff) begin
                                phase_next        = PH_IDLE;
                                packet_count_next = 4'd0;
                                result.burst_done = 1'b1;
                            end else begin
                                phase_next        = PH_PRE;
                                packet_count_next = pkt_inc;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            packet_count_reg <= 4'd0;
            symbol_index_reg <= 7'd0;
            te_slot_reg      <= 6'd0;
            tick_count_reg   <= 16'd0;
            payload_reg      <= 64'd0;
        end else if (step) begin
            phase_reg        <= phase_next;
            packet_count_reg <= packet_count_next;
            symbol_index_reg <= symbol_index_next;
            te_slot_reg      <= te_slot_next;
            tick_count_reg   <= tick_count_next;
            payload_reg      <= payload_next;
        end
    end

`include "keyfob_pwm_packet_encoder_assert.svh"

    // The end of a burst always lands the sequencer back in idle.
    `KFPE_ASSERT_NXT(a_done_to_idle, aclk, aresetn, step && result.burst_done, phase_reg == PH_IDLE, "burst_done without return to idle")
    // No TE slot count ever reaches the longest gap.
    `KFPE_ASSERT_IMP(a_slot_range, aclk, aresetn, busy, te_slot_reg < GAP2_TE[5:0], "te_slot out of range")
    // Inside the data phase the symbol index stays within payload plus tail.
    `KFPE_ASSERT_IMP(a_sym_range, aclk, aresetn, phase_reg == PH_BITS, symbol_index_reg < PACKET_SYMBOLS, "symbol_index out of range")
    // A start while idle always arms the first preamble slot.
    `KFPE_ASSERT_NXT(a_start_arms, aclk, aresetn, step && item.kind && !busy, (phase_reg == PH_PRE) && (te_slot_reg == 6'd0) && (tick_count_reg == 16'd0), "start did not arm preamble")

endmodule

// ----- sv/keyfob_pwm_packet_encoder.sv -----
// Top level of the key fob PWM on-off-keyed packet encoder.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tuser: kind; s_tdata: key_id, button_code, random_byte
//  m_        out        m_tvalid/m_tready  m_tdata: tx_level, busy_res; m_tlast: burst_done
//  APB       in         psel/penable       te_length @0x0, packet_repeats @0x4, preamble_pulses @0x8
//
// Every beat is stepped through the sequencer; one beat is accepted per clock when the
// result side keeps up. An input beat travels through the input register, then the result
// register, to the result side. aresetn is synchronous and active low; it empties both
// stages and returns the sequencer and registers to their reset values. A stalled result
// holds its register, and the input stage holds its beat until the result register frees.
module keyfob_pwm_packet_encoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,  // [27:0] key_id, [31:28] button_code,
                                                        // [39:32] random_byte
    input  logic                              s_tuser,  // [0] kind (0 tick, 1 start)
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // [0] tx_level, [1] busy_res,
                                                        // [7:2] zero
    output logic                              m_tlast,  // burst_done
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kfpe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [kfpe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [kfpe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import kfpe_pkg::*;

    // Configuration registers.
    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    // Input stage.
    logic     in_valid_reg;
    item_t    in_item_reg;

    // Result stage.
    logic     out_valid_reg;
    result_t  out_res_reg;

    result_t  seq_res;
    logic     out_free;
    logic     step;

    // ---------------------------------------------------------------------------------
    // APB: writes land on the access phase; pready is tied high so every access is
    // zero wait state. Low address bits are ignored, the word index is paddr[3:2].
    // ---------------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_TE_LENGTH:       prdata = {16'd0, cfg_reg.te_length};
            REG_PACKET_REPEATS:  prdata = {28'd0, cfg_reg.packet_repeats};
            REG_PREAMBLE_PULSES: prdata = {27'd0, cfg_reg.preamble_pulses};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.te_length       <= TE_LENGTH_RST;
            cfg_reg.packet_repeats  <= PACKET_REPEATS_RST;
            cfg_reg.preamble_pulses <= PREAMBLE_PULSES_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TE_LENGTH:       cfg_reg.te_length       <= pwdata[15:0];
                REG_PACKET_REPEATS:  cfg_reg.packet_repeats  <= pwdata[3:0];
                REG_PREAMBLE_PULSES: cfg_reg.preamble_pulses <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Two-stage stream pipe. The result register frees when it is empty or being taken
    // this cycle; the beat sitting in the input register is then stepped through the
    // sequencer and its result is captured. The input register refills in the same
    // cycle, so back-to-back beats flow at one per clock while the result side keeps up.
    // ---------------------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.kind        <= s_tuser;
            in_item_reg.key_id      <= s_tdata[27:0];
            in_item_reg.button_code <= s_tdata[31:28];
            in_item_reg.random_byte <= s_tdata[39:32];
        end
    end

    // The sequencer owns all burst state and works out the result of the current beat.
    kfpe_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (seq_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= seq_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.busy_res, out_res_reg.tx_level};
    assign m_tlast  = out_res_reg.burst_done;

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for the key fob PWM packet encoder: directed and random beats, live checking.
`timescale 1ns / 100ps

module tb;
    import kfpe_pkg::*;

    // Clock, reset and run control.
    localparam int CLK_HALF_NS    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 6;     // margin after the last owed result
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either side
    localparam int REPORT_CAP     = 100;   // keeps a badly broken build from flooding the log
    localparam int PHASES         = 13;

    // Meaning of the kind bit carried on s_tuser.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Waveform shape, in TE slots and symbols.
    localparam int unsigned PRE_SLOT_COUNT = 2;
    localparam int unsigned SYNC_GAP_TE    = 10;
    localparam int unsigned BIT_SLOT_COUNT = 3;
    localparam int unsigned TAIL_GAP_TE    = 39;
    localparam int unsigned PAYLOAD_BITS   = 64;
    localparam int unsigned TAIL_BITS      = 2;

    // Register values after reset.
    localparam logic [15:0] TE_AT_RESET      = 16'd413;
    localparam logic [3:0]  REPEATS_AT_RESET = 4'd4;
    localparam logic [4:0]  PAIRS_AT_RESET   = 5'd12;

    // Where the encoder is within a packet.
    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_PREAMBLE,
        SEG_SYNC_GAP,
        SEG_DATA,
        SEG_TAIL_GAP
    } segment_t;

    // Tracks the line waveform the encoder should be producing and holds the result
    // beats still owed by the block, oldest first.
    class fob_line_tracker;
        logic [15:0]  te_len;
        logic [3:0]   reps;
        logic [4:0]   pre_pairs;
        segment_t     seg;
        int unsigned  packet_cnt;
        int unsigned  symbol;
        int unsigned  slot;
        int unsigned  tick_cnt;
        logic [63:0]  payload;
        result_t      owed_levels[$];
        int unsigned  mismatches;

        function new();
            te_len     = TE_AT_RESET;
            reps       = REPEATS_AT_RESET;
            pre_pairs  = PAIRS_AT_RESET;
            seg        = SEG_IDLE;
            packet_cnt = 0;
            symbol     = 0;
            slot       = 0;
            tick_cnt   = 0;
            payload    = '0;
            mismatches = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_TE_LENGTH:       te_len = val[15:0];
                REG_PACKET_REPEATS:  reps = val[3:0];
                REG_PREAMBLE_PULSES: pre_pairs = val[4:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return owed_levels.size();
        endfunction

        function bit busy();
            return seg != SEG_IDLE;
        endfunction

        // A register holding zero behaves as one.
        function int unsigned at_least_one(int unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        function logic line_level();
            logic cur_bit;
            cur_bit = (symbol < PAYLOAD_BITS) ? payload[63 - symbol] : 1'b1;
            case (seg)
                SEG_PREAMBLE: return slot == 1;
                SEG_DATA:     return (slot == 0) || (slot == 1 && !cur_bit);
                default:      return 1'b0;
            endcase
        endfunction

        // Moves on by one TE slot; true when this was the last slot of the burst.
        function bit advance_slot();
            int unsigned nxt;
            bit          done;
            nxt  = slot + 1;
            done = 1'b0;
            case (seg)
                SEG_PREAMBLE: begin
                    if (nxt >= PRE_SLOT_COUNT) begin
                        slot   = 0;
                        symbol = (symbol + 1) & 32'h7F;
                        if (symbol >= at_least_one(pre_pairs)) begin
                            seg    = SEG_SYNC_GAP;
                            symbol = 0;
                        end
                    end else begin
                        slot = nxt;
                    end
                end
                SEG_SYNC_GAP: begin
                    if (nxt >= SYNC_GAP_TE) begin
                        slot   = 0;
                        seg    = SEG_DATA;
                        symbol = 0;
                    end else begin
                        slot = nxt;
                    end
                end
                SEG_DATA: begin
                    if (nxt >= BIT_SLOT_COUNT) begin
                        slot   = 0;
                        symbol = (symbol + 1) & 32'h7F;
                        if (symbol >= PAYLOAD_BITS + TAIL_BITS) begin
                            seg    = SEG_TAIL_GAP;
                            symbol = 0;
                        end
                    end else begin
                        slot = nxt;
                    end
                end
                SEG_TAIL_GAP: begin
                    if (nxt >= TAIL_GAP_TE) begin
                        slot       = 0;
                        symbol     = 0;
                        packet_cnt = (packet_cnt + 1) & 32'hF;
                        if (packet_cnt >= at_least_one(reps)) begin
                            seg        = SEG_IDLE;
                            packet_cnt = 0;
                            done       = 1'b1;
                        end else begin
                            seg = SEG_PREAMBLE;
                        end
                    end else begin
                        slot = nxt;
                    end
                end
                default: seg = SEG_IDLE;
            endcase
            return done;
        endfunction

        // Called for every accepted input beat.
        function void note_beat(item_t it);
            result_t r;
            r = '0;
            if (it.kind == KIND_START) begin
                if (seg != SEG_IDLE) begin
                    // Ignored start: reports the level of the current slot.
                    r.tx_level = line_level();
                end else begin
                    payload    = {8'h20, 4'h2, it.button_code, it.random_byte, it.random_byte,
                                  it.key_id, it.button_code};
                    seg        = SEG_PREAMBLE;
                    packet_cnt = 0;
                    symbol     = 0;
                    slot       = 0;
                    tick_cnt   = 0;
                end
                r.busy_res = 1'b1;
            end else if (seg != SEG_IDLE) begin
                r.tx_level = line_level();
                r.busy_res = 1'b1;
                if (tick_cnt + 1 >= at_least_one(te_len)) begin
                    tick_cnt     = 0;
                    r.burst_done = advance_slot();
                end else begin
                    tick_cnt = tick_cnt + 1;
                end
            end
            owed_levels.push_back(r);
        endfunction

        function void report(string what, logic want, logic got);
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s expected %0b actual %0b", $time, what, want, got);
        endfunction

        // Called for every accepted result beat.
        function void check_result(result_t got);
            result_t want;
            if (owed_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: result beat with nothing expected, expected none actual %b",
                             $time, got);
                return;
            end
            want = owed_levels.pop_front();
            if (got.tx_level !== want.tx_level)
                report("tx_level", want.tx_level, got.tx_level);
            if (got.busy_res !== want.busy_res)
                report("busy_res", want.busy_res, got.busy_res);
            if (got.burst_done !== want.burst_done)
                report("burst_done", want.burst_done, got.burst_done);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fob_line_tracker tracker;

    // Idling controls. A quiet side never idles, which gives full-rate stretches.
    bit src_quiet;
    bit sink_quiet;
    int sink_hold;
    int quiet_cycles;

    // Settings per random phase. The table runs through the extremes: the longest TE,
    // the most packets and pulse pairs, and zeros that act as one. Shrinking a register
    // while a burst runs makes the running counter pass its new limit.
    int unsigned te_tab[PHASES]  = '{1, 65535, 1, 2, 0, 1, 3, 1, 2, 1, 65535, 1, 1};
    int unsigned rep_tab[PHASES] = '{1, 4, 15, 1, 0, 2, 1, 1, 3, 1, 15, 1, 1};
    int unsigned pre_tab[PHASES] = '{1, 12, 31, 2, 0, 1, 3, 31, 1, 0, 1, 4, 1};

    keyfob_pwm_packet_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #CLK_HALF_NS;
        aclk = 1'b1;
        #CLK_HALF_NS;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Both channels are sampled at the rising edge, where the values seen are the ones
    // settled before the edge. Input beats feed the tracker; result beats are checked
    // against the oldest owed result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_beat(item_t'({s_tuser, s_tdata[27:0], s_tdata[31:28],
                                           s_tdata[39:32]}));
            if (m_tvalid && m_tready)
                tracker.check_result(result_t'({m_tdata[0], m_tdata[1], m_tlast}));
        end
    end

    // Result side: m_tready drops for random stretches unless the side is quiet.
    // Only one nonblocking write to m_tready happens per edge.
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end else begin
            sink_hold = sink_quiet ? 0 : pick_gap();
            if (sink_hold > 0) begin
                sink_hold = sink_hold - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a stuck handshake on either side ends the run as a failure.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic item_t make_item(logic kind, logic [27:0] id, logic [3:0] btn,
                                        logic [7:0] rnd);
        item_t it;
        it.kind        = kind;
        it.key_id      = id;
        it.button_code = btn;
        it.random_byte = rnd;
        return it;
    endfunction

    // Random traffic is mostly well-formed bursts: an idle encoder gets a start soon, a
    // busy one gets ticks with the odd stray start mixed in. Unused fields carry noise.
    function automatic item_t random_beat();
        item_t it;
        int    pick;
        pick           = $urandom_range(0, 9);
        it.key_id      = (pick == 0) ? 28'h0 :
                         (pick == 1) ? 28'hFFFFFFF : 28'($urandom_range(0, 28'hFFFFFFF));
        it.button_code = 4'($urandom_range(0, 15));
        it.random_byte = 8'($urandom_range(0, 255));
        if (!tracker.busy())
            it.kind = ($urandom_range(0, 3) != 0) ? KIND_START : KIND_TICK;
        else
            it.kind = ($urandom_range(0, 39) == 0) ? KIND_START : KIND_TICK;
        return it;
    endfunction

    function automatic item_t tick_beat();
        item_t it;
        it      = random_beat();
        it.kind = KIND_TICK;
        return it;
    endfunction

    // Presents one beat, after a random gap, and returns at the edge that accepts it.
    // s_tvalid stays high into the next call when there is no gap.
    task automatic send_beat(item_t it);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.random_byte, it.button_code, it.key_id};
        do @(posedge aclk); while (!s_tready);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops the sender and waits until every owed result has come back, plus a margin.
    // The first edge lets the monitor log the last accepted beat.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Registers are written only with the pipeline empty; a burst may still be running.
    task automatic load_settings(int unsigned te, int unsigned reps, int unsigned pairs);
        wait_drained();
        write_reg(REG_TE_LENGTH, te);
        write_reg(REG_PACKET_REPEATS, reps);
        write_reg(REG_PREAMBLE_PULSES, pairs);
    endtask

    task automatic run_out_burst();
        while (tracker.busy()) send_beat(tick_beat());
    endtask

    initial begin
        int n;
        tracker  = new();
        // Every input is known from time zero.
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b1;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
        sink_hold  = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with the reset settings. Ticks while idle, all-ones and all-zero.
        send_beat(make_item(KIND_TICK, 28'hFFFFFFF, 4'hF, 8'hFF));
        send_beat(make_item(KIND_TICK, 28'h0, 4'h0, 8'h00));
        // A start with every field at its top, random byte 255 included.
        send_beat(make_item(KIND_START, 28'hFFFFFFF, 4'hF, 8'hFF));
        // Starts while busy are ignored but still report the line.
        send_beat(make_item(KIND_START, 28'h0, 4'h0, 8'h00));
        send_beat(make_item(KIND_START, 28'h5A5A5A5, 4'h2, 8'h3C));
        repeat (4) send_beat(make_item(KIND_TICK, 28'hA5A5A5A, 4'h5, 8'hC3));

        // Zeros in all three registers act as one. The long TE count already running now
        // passes its limit on the next tick.
        load_settings(0, 0, 0);
        run_out_burst();
        // A start with every field at zero, and the same start again while it runs.
        send_beat(make_item(KIND_START, 28'h0, 4'h0, 8'h00));
        send_beat(make_item(KIND_START, 28'h0, 4'h0, 8'h00));
        send_beat(make_item(KIND_TICK, 28'h0, 4'h0, 8'h00));
        run_out_burst();

        // Random phases, each with its own settings and idling mix. Every settings change
        // pauses the sender until the block has returned every owed result.
        for (int p = 0; p < PHASES; p++) begin
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            load_settings(te_tab[p], rep_tab[p], pre_tab[p]);
            n = $urandom_range(60, 115);
            repeat (n) send_beat(random_beat());
        end

        // Drain; a result that never comes is caught by the watchdog.
        wait_drained();
        if (tracker.mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/kfpe_pkg.sv
sv/kfpe_seq.sv
sv/keyfob_pwm_packet_encoder.sv
dv/tb.sv
